FILE: rtl/dre_pkg.sv
// ----------------------------------------------------------------------------
// dre_pkg
// Shared types and constants for the DNS reply address extractor: the byte
// stream transaction, the result transaction and the parser constants.
// ----------------------------------------------------------------------------
`default_nettype none

package dre_pkg;

  // one byte of the reply message
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       last_byte;
  } msg_t;

  // one result per message
  typedef struct packed {
    logic        found;
    logic [31:0] ipv4_address;
  } res_t;

  localparam int unsigned APB_ADDR_W   = 2;
  localparam int unsigned APB_DATA_W   = 32;
  localparam int unsigned ID_W         = 16;

  localparam int unsigned CNT_W        = 4;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned FIXED_BYTES  = 10;
  localparam int unsigned QTAIL_BYTES  = 4;

  localparam logic [15:0] FLAG_REPLY   = 16'h8000;
  localparam logic [15:0] RCODE_MASK   = 16'h000F;
  localparam logic [7:0]  POINTER_MARK = 8'hC0;
  localparam logic [15:0] TYPE_A       = 16'd1;
  localparam logic [15:0] CLASS_IN     = 16'd1;
  localparam logic [15:0] ADDR_LEN     = 16'd4;

  // register addresses
  localparam logic [APB_ADDR_W-1:0] REG_EXPECTED_ID = 2'd0;

  // outcome codes
  localparam logic [1:0] OUT_PENDING = 2'd0;
  localparam logic [1:0] OUT_FOUND   = 2'd1;
  localparam logic [1:0] OUT_FAILED  = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/dns_reply_address_extractor.sv
// ----------------------------------------------------------------------------
// dns_reply_address_extractor
// Parses a DNS reply streamed one byte per transaction and reports the first
// Internet-class A record with a 4-byte address, one result per message.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, set by the single parser state update, except
//   that a final byte is held while an earlier result still waits on res_ready.
// Flow: a byte is registered in the input stage on accept and parsed from there;
//   the result is registered into res as the final byte leaves the input stage.
// Reset: rst (synchronous) clears the parser to the header phase, empties the
//   input and result stages and sets expected_id to zero.
`default_nettype none

module dns_reply_address_extractor (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               msg_valid,
  output      logic                               msg_ready,
  input  wire dre_pkg::msg_t                      msg,
  output      logic                               res_valid,
  input  wire logic                               res_ready,
  output      dre_pkg::res_t                      res,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [dre_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [dre_pkg::APB_DATA_W-1:0]     pwdata,
  output      logic [dre_pkg::APB_DATA_W-1:0]     prdata,
  output      logic                               pready
);
  import dre_pkg::*;

  localparam logic [3:0] PH_HEADER  = 4'd0;
  localparam logic [3:0] PH_NAME    = 4'd1;
  localparam logic [3:0] PH_LABEL   = 4'd2;
  localparam logic [3:0] PH_POINTER = 4'd3;
  localparam logic [3:0] PH_QTAIL   = 4'd4;
  localparam logic [3:0] PH_RFIXED  = 4'd5;
  localparam logic [3:0] PH_RDATA   = 4'd6;
  localparam logic [3:0] PH_RADDR   = 4'd7;
  localparam logic [3:0] PH_DONE    = 4'd8;

  // configuration
  logic [ID_W-1:0] expected_id;

  assign pready = 1'b1;
  assign prdata = {{(APB_DATA_W-ID_W){1'b0}}, expected_id};

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= '0;
    end else if (psel && penable && pwrite && pready && paddr == REG_EXPECTED_ID) begin
      expected_id <= pwdata[ID_W-1:0];
    end
  end

  // input stage
  logic s_valid;
  msg_t s_msg;
  logic advance;

  assign advance   = s_valid && !(s_msg.last_byte && res_valid && !res_ready);
  assign msg_ready = !s_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (msg_ready) begin
      s_valid <= msg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (msg_ready && msg_valid) begin
      s_msg <= msg;
    end
  end

  // parser state
  logic [3:0]       phase, phase_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]      questions_left, questions_left_next;
  logic [15:0]      answers_left, answers_left_next;
  logic [7:0]       label_bytes_left, label_bytes_left_next;
  logic [15:0]      record_type, record_type_next;
  logic [15:0]      record_class, record_class_next;
  logic [15:0]      data_bytes_left, data_bytes_left_next;
  logic [31:0]      address_shift, address_shift_next;
  logic [1:0]       outcome, outcome_next;

  logic [7:0]       b;
  logic [31:0]      shifted;
  logic [15:0]      w;
  logic [CNT_W-1:0] cnt_inc;

  assign b       = s_msg.msg_byte;
  assign shifted = {address_shift[23:0], b};
  assign w       = shifted[15:0];
  assign cnt_inc = byte_count + CNT_W'(1);

  always_comb begin
    phase_next            = phase;
    byte_count_next       = byte_count;
    questions_left_next   = questions_left;
    answers_left_next     = answers_left;
    label_bytes_left_next = label_bytes_left;
    record_type_next      = record_type;
    record_class_next     = record_class;
    data_bytes_left_next  = data_bytes_left;
    address_shift_next    = address_shift;
    outcome_next          = outcome;

    unique case (phase)
      PH_HEADER: begin
        address_shift_next = shifted;
        byte_count_next    = cnt_inc;
        if (cnt_inc == CNT_W'(2)) begin
          if (w != expected_id) begin
            outcome_next = OUT_FAILED;
            phase_next   = PH_DONE;
          end
        end else if (cnt_inc == CNT_W'(4)) begin
          if ((w & FLAG_REPLY) == '0 || (w & RCODE_MASK) != '0) begin
            outcome_next = OUT_FAILED;
            phase_next   = PH_DONE;
          end
        end else if (cnt_inc == CNT_W'(6)) begin
          questions_left_next = w;
        end else if (cnt_inc == CNT_W'(8)) begin
          answers_left_next = w;
          if (w == '0) begin
            outcome_next = OUT_FAILED;
            phase_next   = PH_DONE;
          end
        end else if (cnt_inc >= CNT_W'(HEADER_BYTES)) begin
          address_shift_next = '0;
          byte_count_next    = '0;
          phase_next         = PH_NAME;
        end
      end
      PH_NAME: begin
        if (b == '0) begin
          byte_count_next = '0;
          phase_next      = (questions_left != '0) ? PH_QTAIL : PH_RFIXED;
        end else if ((b & POINTER_MARK) == POINTER_MARK) begin
          phase_next = PH_POINTER;
        end else begin
          label_bytes_left_next = b;
          phase_next            = PH_LABEL;
        end
      end
      PH_LABEL: begin
        label_bytes_left_next = label_bytes_left - 8'd1;
        if (label_bytes_left_next == '0) begin
          phase_next = PH_NAME;
        end
      end
      PH_POINTER: begin
        byte_count_next = '0;
        phase_next      = (questions_left != '0) ? PH_QTAIL : PH_RFIXED;
      end
      PH_QTAIL: begin
        byte_count_next = cnt_inc;
        if (cnt_inc >= CNT_W'(QTAIL_BYTES)) begin
          byte_count_next     = '0;
          questions_left_next = questions_left - 16'd1;
          phase_next          = PH_NAME;
        end
      end
      PH_RFIXED: begin
        byte_count_next = cnt_inc;
        if (cnt_inc <= CNT_W'(2)) begin
          record_type_next = {record_type[7:0], b};
        end else if (cnt_inc <= CNT_W'(4)) begin
          record_class_next = {record_class[7:0], b};
        end else if (cnt_inc >= CNT_W'(FIXED_BYTES - 1)) begin
          data_bytes_left_next = {data_bytes_left[7:0], b};
        end
        if (cnt_inc >= CNT_W'(FIXED_BYTES)) begin
          byte_count_next = '0;
          if (record_type_next == TYPE_A && record_class_next == CLASS_IN &&
              data_bytes_left_next == ADDR_LEN) begin
            address_shift_next = '0;
            phase_next         = PH_RADDR;
          end else if (data_bytes_left_next == '0) begin
            answers_left_next = answers_left - 16'd1;
            if (answers_left_next == '0) begin
              outcome_next = OUT_FAILED;
              phase_next   = PH_DONE;
            end else begin
              phase_next = PH_NAME;
            end
          end else begin
            phase_next = PH_RDATA;
          end
        end
      end
      PH_RDATA: begin
        data_bytes_left_next = data_bytes_left - 16'd1;
        if (data_bytes_left_next == '0) begin
          answers_left_next = answers_left - 16'd1;
          if (answers_left_next == '0) begin
            outcome_next = OUT_FAILED;
            phase_next   = PH_DONE;
          end else begin
            phase_next = PH_NAME;
          end
        end
      end
      PH_RADDR: begin
        address_shift_next   = shifted;
        data_bytes_left_next = data_bytes_left - 16'd1;
        if (data_bytes_left_next == '0) begin
          outcome_next = OUT_FOUND;
          phase_next   = PH_DONE;
        end
      end
      default: begin
        // done: bytes ignored until the final one
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && s_msg.last_byte)) begin
      phase            <= PH_HEADER;
      byte_count       <= '0;
      questions_left   <= '0;
      answers_left     <= '0;
      label_bytes_left <= '0;
      record_type      <= '0;
      record_class     <= '0;
      data_bytes_left  <= '0;
      address_shift    <= '0;
      outcome          <= OUT_PENDING;
    end else if (advance) begin
      phase            <= phase_next;
      byte_count       <= byte_count_next;
      questions_left   <= questions_left_next;
      answers_left     <= answers_left_next;
      label_bytes_left <= label_bytes_left_next;
      record_type      <= record_type_next;
      record_class     <= record_class_next;
      data_bytes_left  <= data_bytes_left_next;
      address_shift    <= address_shift_next;
      outcome          <= outcome_next;
    end
  end

  // result stage
  res_t res_next;

  always_comb begin
    if (outcome_next == OUT_FOUND) begin
      res_next.found        = 1'b1;
      res_next.ipv4_address = address_shift_next;
    end else begin
      res_next.found        = 1'b0;
      res_next.ipv4_address = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && s_msg.last_byte) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s_msg.last_byte) begin
      res <= res_next;
    end
  end

  // checks
  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.found) |-> (res.ipv4_address == '0))
    else $error("failed result carries a nonzero address");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (advance && s_msg.last_byte) |=> (phase == PH_HEADER && outcome == OUT_PENDING))
    else $error("parser not cleared after final byte");

  a_found_is_done: assert property (@(posedge clk) disable iff (rst)
    (outcome != OUT_PENDING) |-> (phase == PH_DONE))
    else $error("outcome set outside done phase");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !(advance && s_msg.last_byte))
    else $error("result overwritten before taken");

endmodule

`default_nettype wire

FILE: verif/dns_reply_address_extractor_tb.sv
// ----------------------------------------------------------------------------
// dns_reply_address_extractor_tb
// Streams DNS replies byte by byte into the extractor and checks each
// per-message result against a cycle-free parser model held in a scoreboard.
// Directed replies cover header rejects, skipped records, truncation, pointer
// and reserved-prefix names. Random replies follow with random content, some
// corrupted or cut short, plus raw noise. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module dns_reply_address_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dre_pkg::*;

  localparam int unsigned ITEMS          = 1850;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned DRAIN_CYCLES   = 8;

  typedef enum logic [3:0] {
    ST_HEADER, ST_NAME, ST_LABEL, ST_POINTER, ST_QTAIL,
    ST_RFIXED, ST_RDATA, ST_RADDR, ST_DONE
  } parse_state_e;

  // Tracks parser state per accepted byte and queues the address each
  // terminated message should yield.
  class address_scoreboard;
    logic [15:0]  txn_id;
    parse_state_e state;
    logic [15:0]  pos;
    logic [15:0]  questions_left;
    logic [15:0]  answers_left;
    logic [7:0]   label_left;
    logic [15:0]  rr_type;
    logic [15:0]  rr_class;
    logic [15:0]  rdata_left;
    logic [31:0]  shift_reg;
    logic [1:0]   outcome;
    res_t         expected_addrs[$];
    int unsigned  accepted_bytes;
    int unsigned  mismatches;

    function new();
      txn_id         = '0;
      accepted_bytes = 0;
      mismatches     = 0;
      restart_message();
    endfunction

    function void restart_message();
      state          = ST_HEADER;
      pos            = '0;
      questions_left = '0;
      answers_left   = '0;
      label_left     = '0;
      rr_type        = '0;
      rr_class       = '0;
      rdata_left     = '0;
      shift_reg      = '0;
      outcome        = OUT_PENDING;
    endfunction

    function void reject();
      outcome = OUT_FAILED;
      state   = ST_DONE;
    endfunction

    function void name_done();
      pos   = '0;
      state = (questions_left != 0) ? ST_QTAIL : ST_RFIXED;
    endfunction

    function void record_done();
      answers_left = answers_left - 16'd1;
      if (answers_left == 0) reject();
      else state = ST_NAME;
    endfunction

    function int unsigned pending();
      return expected_addrs.size();
    endfunction

    function void note_byte(msg_t m);
      logic [7:0]  b;
      logic [15:0] w;
      res_t        exp_res;
      b = m.msg_byte;
      accepted_bytes++;
      case (state)
        ST_HEADER: begin
          shift_reg = {shift_reg[23:0], b};
          pos       = pos + 16'd1;
          w         = shift_reg[15:0];
          if (pos == 2) begin
            if (w != txn_id) reject();
          end else if (pos == 4) begin
            if ((w & FLAG_REPLY) == 0 || (w & RCODE_MASK) != 0) reject();
          end else if (pos == 6) begin
            questions_left = w;
          end else if (pos == 8) begin
            answers_left = w;
            if (w == 0) reject();
          end else if (pos >= HEADER_BYTES) begin
            shift_reg = '0;
            pos       = '0;
            state     = ST_NAME;
          end
        end
        ST_NAME: begin
          if (b == 0) name_done();
          else if ((b & POINTER_MARK) == POINTER_MARK) state = ST_POINTER;
          else begin
            // 01/10 prefixes fall through as plain label lengths
            label_left = b;
            state      = ST_LABEL;
          end
        end
        ST_LABEL: begin
          label_left = label_left - 8'd1;
          if (label_left == 0) state = ST_NAME;
        end
        ST_POINTER: name_done();
        ST_QTAIL: begin
          pos = pos + 16'd1;
          if (pos >= QTAIL_BYTES) begin
            pos            = '0;
            questions_left = questions_left - 16'd1;
            state          = ST_NAME;
          end
        end
        ST_RFIXED: begin
          pos = pos + 16'd1;
          if (pos <= 2) rr_type = {rr_type[7:0], b};
          else if (pos <= 4) rr_class = {rr_class[7:0], b};
          else if (pos >= 9) rdata_left = {rdata_left[7:0], b};
          if (pos >= FIXED_BYTES) begin
            pos = '0;
            if (rr_type == TYPE_A && rr_class == CLASS_IN && rdata_left == ADDR_LEN) begin
              shift_reg = '0;
              state     = ST_RADDR;
            end else if (rdata_left == 0) begin
              record_done();
            end else begin
              state = ST_RDATA;
            end
          end
        end
        ST_RDATA: begin
          rdata_left = rdata_left - 16'd1;
          if (rdata_left == 0) record_done();
        end
        ST_RADDR: begin
          shift_reg  = {shift_reg[23:0], b};
          rdata_left = rdata_left - 16'd1;
          if (rdata_left == 0) begin
            outcome = OUT_FOUND;
            state   = ST_DONE;
          end
        end
        default: ;
      endcase
      if (m.last_byte) begin
        exp_res.found        = (outcome == OUT_FOUND);
        exp_res.ipv4_address = (outcome == OUT_FOUND) ? shift_reg : 32'h0;
        expected_addrs.push_back(exp_res);
        restart_message();
      end
    endfunction

    task report(string what);
      mismatches++;
      $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task check_result(res_t got);
      res_t exp_res;
      if (expected_addrs.size() == 0) begin
        report($sformatf("result found=%0b addr=%08h with no transaction expected",
                         got.found, got.ipv4_address));
      end else begin
        exp_res = expected_addrs.pop_front();
        if (got.found != exp_res.found)
          report($sformatf("found: expected %0b got %0b", exp_res.found, got.found));
        if (got.ipv4_address != exp_res.ipv4_address)
          report($sformatf("ipv4_address: expected %08h got %08h",
                           exp_res.ipv4_address, got.ipv4_address));
      end
    endtask
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  msg_valid = 1'b0;
  logic                  msg_ready;
  msg_t                  msg       = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  res_t                  res;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  address_scoreboard sb;
  logic [7:0]        pkt[$];
  bit                feed_burst  = 1'b0;
  bit                drain_burst = 1'b0;
  int unsigned       idle_cycles = 0;

  always #6 clk = ~clk;

  dns_reply_address_extractor u_top (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_ready (msg_ready),
    .msg       (msg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // ---- message building ----
  function automatic void put16(input logic [15:0] v);
    pkt.push_back(v[15:8]);
    pkt.push_back(v[7:0]);
  endfunction

  function automatic void put_header(input logic [15:0] id, input logic [15:0] flags,
                                     input logic [15:0] qd, input logic [15:0] an);
    put16(id);
    put16(flags);
    put16(qd);
    put16(an);
    put16(16'($urandom_range(0, 65535)));
    put16(16'($urandom_range(0, 65535)));
  endfunction

  function automatic void put_name();
    int unsigned labels = $urandom_range(0, 3);
    int unsigned len;
    for (int i = 0; i < labels; i++) begin
      // now and then a length with a reserved 01/10 prefix
      len = ($urandom_range(0, 31) == 0) ? $urandom_range(64, 191) : $urandom_range(1, 8);
      pkt.push_back(len[7:0]);
      repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1)) put16({2'b11, 14'($urandom_range(0, 16383))});
    else pkt.push_back(8'h00);
  endfunction

  function automatic void put_record(input logic [15:0] rtype, input logic [15:0] rclass,
                                     input logic [15:0] rlen, input logic [31:0] addr);
    put16(rtype);
    put16(rclass);
    put16(16'($urandom_range(0, 65535)));
    put16(16'($urandom_range(0, 65535)));
    put16(rlen);
    if (rlen == ADDR_LEN) begin
      put16(addr[31:16]);
      put16(addr[15:0]);
    end else begin
      repeat (rlen) pkt.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void put_simple_reply(input logic [15:0] id, input logic [15:0] flags,
                                           input logic [15:0] an, input logic [31:0] addr);
    put_header(id, flags, 16'd0, an);
    pkt.push_back(8'h00);
    put_record(TYPE_A, CLASS_IN, ADDR_LEN, addr);
  endfunction

  // ---- drivers ----
  task automatic send_byte(input logic [7:0] data, input logic last);
    int unsigned gap;
    gap = feed_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_valid <= 1'b1;
    msg       <= '{msg_byte: data, last_byte: last};
    do @(posedge clk); while (!msg_ready);
  endtask

  task automatic send_packet(input bit terminate);
    foreach (pkt[i]) send_byte(pkt[i], terminate && (i == pkt.size() - 1));
    pkt.delete();
  endtask

  task automatic apb_xfer(input logic write, input logic [15:0] wdata,
                          output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= REG_EXPECTED_ID;
    pwdata  <= {16'h0000, wdata};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // only while the parser is idle: drop valid, drain results, let it settle
  task automatic load_id(input logic [15:0] id);
    logic [APB_DATA_W-1:0] rd;
    msg_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_xfer(1'b1, id, rd);
    sb.txn_id = id;
    @(posedge clk);
    apb_xfer(1'b0, 16'h0000, rd);
    if (rd != {16'h0000, id})
      sb.report($sformatf("expected_id readback: expected %04h got %08h", id, rd));
  endtask

  // ---- monitor and watchdog ----
  always @(posedge clk) begin
    if (!rst) begin
      if (msg_valid && msg_ready) sb.note_byte(msg);
      if (res_valid && res_ready) sb.check_result(res);
      if ((msg_valid && msg_ready) || (res_valid && res_ready) || (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---- result sink ----
  initial begin : result_sink
    int unsigned stall;
    @(posedge clk);
    forever begin
      stall = drain_burst ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      if ($urandom_range(0, 15) == 0) drain_burst = !drain_burst;
    end
  end

  // ---- stimulus ----
  initial begin : stimulus
    int unsigned qd;
    int unsigned an;
    int unsigned keep;
    bit          terminate;
    bit          stream_open;
    logic [15:0] id;

    sb          = new();
    stream_open = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // minimal reply, all-ones address
    load_id(16'h0000);
    put_simple_reply(16'h0000, 16'h8180, 16'd1, 32'hFFFF_FFFF);
    send_packet(1'b1);

    // question, CNAME skipped via pointer names, zero address, trailing bytes
    load_id(16'hFFFF);
    put_header(16'hFFFF, 16'h8000, 16'd1, 16'd2);
    put_name();
    put16(TYPE_A);
    put16(CLASS_IN);
    put16(16'hC00C);
    put_record(16'd5, CLASS_IN, 16'd3, 32'h0);
    put16(16'hC00C);
    put_record(TYPE_A, CLASS_IN, ADDR_LEN, 32'h0000_0000);
    repeat (3) pkt.push_back(8'hFF);
    send_packet(1'b1);

    // header rejects: id mismatch, reply bit clear, nonzero rcode, no answers
    put_simple_reply(16'h1234, 16'h8180, 16'd1, 32'h1111_1111);
    send_packet(1'b1);
    put_simple_reply(16'hFFFF, 16'h0180, 16'd1, 32'h2222_2222);
    send_packet(1'b1);
    put_simple_reply(16'hFFFF, 16'h8183, 16'd1, 32'h3333_3333);
    send_packet(1'b1);
    put_simple_reply(16'hFFFF, 16'h8180, 16'd0, 32'h4444_4444);
    send_packet(1'b1);

    // answers exhausted: empty A, AAAA, A in a non-Internet class
    put_header(16'hFFFF, 16'h8180, 16'd0, 16'd3);
    pkt.push_back(8'h00);
    put_record(TYPE_A, CLASS_IN, 16'd0, 32'h0);
    put16(16'hC00C);
    put_record(16'd28, CLASS_IN, 16'd16, 32'h0);
    pkt.push_back(8'h00);
    put_record(TYPE_A, 16'd3, ADDR_LEN, 32'h5555_5555);
    send_packet(1'b1);

    // cut off inside the address
    put_simple_reply(16'hFFFF, 16'h8180, 16'd1, 32'h0A0B_0C0D);
    void'(pkt.pop_back());
    send_packet(1'b1);

    // reserved 01 and 10 length prefixes read as plain labels
    put_header(16'hFFFF, 16'h8180, 16'd1, 16'd1);
    pkt.push_back(8'h41);
    repeat (65) pkt.push_back(8'($urandom_range(0, 255)));
    pkt.push_back(8'h00);
    put16(TYPE_A);
    put16(CLASS_IN);
    pkt.push_back(8'h80);
    repeat (128) pkt.push_back(8'($urandom_range(0, 255)));
    pkt.push_back(8'h00);
    put_record(TYPE_A, CLASS_IN, ADDR_LEN, 32'h0102_0304);
    send_packet(1'b1);

    // lone final byte
    pkt.push_back(8'hFF);
    send_packet(1'b1);

    // unterminated fragment runs on into the next reply
    repeat (5) pkt.push_back(8'($urandom_range(0, 255)));
    send_packet(1'b0);
    put_simple_reply(16'hFFFF, 16'h8180, 16'd1, 32'hC0A8_0001);
    send_packet(1'b1);

    // random replies
    while (sb.accepted_bytes < ITEMS) begin
      if (!stream_open && $urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0:       id = 16'h0000;
          1:       id = 16'hFFFF;
          default: id = 16'($urandom_range(0, 65535));
        endcase
        load_id(id);
      end
      if ($urandom_range(0, 3) == 0) feed_burst = !feed_burst;

      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 20)) pkt.push_back(8'($urandom_range(0, 255)));
        terminate = ($urandom_range(0, 4) != 0);
      end else begin
        qd = $urandom_range(0, 2);
        an = $urandom_range(1, 3);
        id = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535)) : sb.txn_id;
        put_header(id, 16'h8000 | (16'($urandom_range(0, 65535)) & 16'h7FF0),
                   16'(qd), 16'(an));
        repeat (qd) begin
          put_name();
          put16(16'($urandom_range(0, 65535)));
          put16(16'($urandom_range(0, 65535)));
        end
        repeat (an) begin
          put_name();
          case ($urandom_range(0, 3))
            0, 1: put_record(TYPE_A, CLASS_IN, ADDR_LEN, $urandom);
            2:    put_record($urandom_range(0, 1) ? TYPE_A : 16'd28,
                             $urandom_range(0, 1) ? CLASS_IN : 16'd3,
                             16'($urandom_range(0, 8)), $urandom);
            default: put_record(16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 6)), $urandom);
          endcase
        end
        repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom_range(0, 255)));
        // occasional corrupted byte or early cut
        if ($urandom_range(0, 7) == 0)
          pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) begin
          keep = $urandom_range(1, pkt.size());
          while (pkt.size() > keep) void'(pkt.pop_back());
        end
        terminate = 1'b1;
      end
      send_packet(terminate);
      stream_open = !terminate;
    end

    msg_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/dre_pkg.sv
rtl/dns_reply_address_extractor.sv
verif/dns_reply_address_extractor_tb.sv
